FILE: rtl/core/spt_pkg.sv
// ----------------------------------------------------------------------------
// spt_pkg
// Types, codes, angle constants and helper functions of the Stanley path
// tracker.
// ----------------------------------------------------------------------------
package spt_pkg;

    localparam int C_PATH_DEPTH   = 1024;
    localparam int C_CORDIC_STEPS = 16;
    localparam int C_XYW          = 52;
    localparam int C_ZW           = 34;

    localparam logic signed [C_ZW-1:0] C_ANG_PI      = 34'sd843314857;
    localparam logic signed [C_ZW-1:0] C_ANG_HALF_PI = 34'sd421657428;
    localparam logic signed [C_ZW:0]   C_ANG_TWO_PI  = 35'sd1686629714;
    localparam logic signed [C_XYW-1:0] C_GAIN30     = 52'sd652032874;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_TRACK = 1'b1;

    localparam logic CM_ROT = 1'b0;
    localparam logic CM_VEC = 1'b1;

    typedef enum logic [1:0] {
        CFG_PATH_LENGTH = 2'd0,
        CFG_WHEEL_BASE  = 2'd1,
        CFG_GAIN_K      = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic               opcode;
        logic [9:0]         point_index;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [15:0] heading;
        logic [15:0]        speed;
        logic [9:0]         last_target;
    } t_in;

    typedef struct packed {
        logic signed [16:0] steering_angle;
        logic [9:0]         target_index;
        logic signed [31:0] cross_track_error;
    } t_out;

    typedef enum logic [4:0] {
        S_IDLE,
        S_LD_MOD,
        S_LD_WAIT,
        S_LD_WR,
        S_ROT,
        S_ROT_WAIT,
        S_FMUL,
        S_FSAT,
        S_SCAN,
        S_SCAN_WAIT,
        S_EMUL,
        S_EFIN,
        S_TMOD_WAIT,
        S_TRD,
        S_ANG,
        S_ANG_WAIT,
        S_ANG_SAVE,
        S_TD,
        S_TD_WAIT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic accept;
        logic ld_mod;
        logic mem_wr;
        logic rot_start;
        logic front;
        logic front_sat;
        logic scan_start;
        logic err_mul;
        logic tgt_mod;
        logic err_fin;
        logic ang_start;
        logic ang_save;
        logic td_start;
        logic out_fire;
    } t_cmd;

    typedef struct packed {
        logic mod_done;
        logic cordic_done;
        logic scan_done;
    } t_stat;

    function automatic logic [27:0] atan_lut(input logic [4:0] i);
        case (i)
            5'd0:    return 28'd210828714;
            5'd1:    return 28'd124459457;
            5'd2:    return 28'd65760959;
            5'd3:    return 28'd33381290;
            5'd4:    return 28'd16755422;
            5'd5:    return 28'd8385879;
            5'd6:    return 28'd4193963;
            5'd7:    return 28'd2097109;
            5'd8:    return 28'd1048571;
            5'd9:    return 28'd524287;
            5'd10:   return 28'd262144;
            5'd11:   return 28'd131072;
            5'd12:   return 28'd65536;
            5'd13:   return 28'd32768;
            5'd14:   return 28'd16384;
            5'd15:   return 28'd8192;
            5'd16:   return 28'd4096;
            5'd17:   return 28'd2048;
            5'd18:   return 28'd1024;
            5'd19:   return 28'd512;
            5'd20:   return 28'd256;
            5'd21:   return 28'd128;
            5'd22:   return 28'd64;
            5'd23:   return 28'd32;
            default: return 28'd0;
        endcase
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end else begin
            return v[31:0];
        end
    endfunction

endpackage

FILE: rtl/core/spt_cordic.sv
// ----------------------------------------------------------------------------
// spt_cordic
// Shared iterative CORDIC: rotation mode for sine and cosine, vectoring
// mode for atan2. One iteration per cycle.
// ----------------------------------------------------------------------------
module spt_cordic
    import spt_pkg::*;
#(
    parameter int STEPS = C_CORDIC_STEPS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic                    i_mode,
    input  logic signed [C_XYW-1:0] i_x,
    input  logic signed [C_XYW-1:0] i_y,
    input  logic signed [C_ZW-1:0]  i_z,
    output logic                    o_done,
    output logic signed [C_XYW-1:0] o_x,
    output logic signed [C_XYW-1:0] o_y,
    output logic signed [C_ZW-1:0]  o_z
);

    logic signed [C_XYW-1:0] r_x, r_y, n_x, n_y, w_xs, w_ys;
    logic signed [C_ZW-1:0]  r_z, n_z, w_atan;
    logic [4:0]              r_step;
    logic                    r_act, r_done, r_neg, r_zero, r_mode;
    logic                    w_sigma, w_last;

    always_comb begin
        w_xs    = r_x >>> r_step;
        w_ys    = r_y >>> r_step;
        w_atan  = signed'(C_ZW'(atan_lut(r_step)));
        w_sigma = (r_mode == CM_ROT) ? !r_z[C_ZW-1] : r_y[C_XYW-1];
        w_last  = (r_step == 5'(STEPS - 1));
        if (w_sigma) begin
            n_x = r_x - w_ys;
            n_y = r_y + w_xs;
            n_z = r_z - w_atan;
        end else begin
            n_x = r_x + w_ys;
            n_y = r_y - w_xs;
            n_z = r_z + w_atan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act  <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_act  <= 1'b1;
                r_step <= '0;
                r_mode <= i_mode;
                r_neg  <= 1'b0;
                r_zero <= 1'b0;
                if (i_mode == CM_ROT) begin
                    r_x <= C_GAIN30;
                    r_y <= '0;
                    if (i_z > C_ANG_HALF_PI) begin
                        r_z   <= i_z - C_ANG_PI;
                        r_neg <= 1'b1;
                    end else if (i_z < -C_ANG_HALF_PI) begin
                        r_z   <= i_z + C_ANG_PI;
                        r_neg <= 1'b1;
                    end else begin
                        r_z <= i_z;
                    end
                end else begin
                    r_zero <= (i_x == '0) && (i_y == '0);
                    if (i_x[C_XYW-1] && !i_y[C_XYW-1]) begin
                        r_x <= i_y;
                        r_y <= -i_x;
                        r_z <= C_ANG_HALF_PI;
                    end else if (i_x[C_XYW-1]) begin
                        r_x <= -i_y;
                        r_y <= i_x;
                        r_z <= -C_ANG_HALF_PI;
                    end else begin
                        r_x <= i_x;
                        r_y <= i_y;
                        r_z <= '0;
                    end
                end
            end else if (r_act) begin
                r_step <= r_step + 5'd1;
                r_x    <= (w_last && r_neg) ? -n_x : n_x;
                r_y    <= (w_last && r_neg) ? -n_y : n_y;
                r_z    <= (w_last && r_zero) ? '0 : n_z;
                if (w_last) begin
                    r_act  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;

endmodule

FILE: rtl/core/spt_dp.sv
// ----------------------------------------------------------------------------
// spt_dp
// Datapath: configuration registers, path point memories, slot remainder
// unit, front axle arithmetic, pipelined nearest point scan, cross-track
// error and steering output.
// ----------------------------------------------------------------------------
module spt_dp
    import spt_pkg::*;
#(
    parameter int PATH_DEPTH   = C_PATH_DEPTH,
    parameter int CORDIC_STEPS = C_CORDIC_STEPS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  t_in         i_in,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    output logic        o_valid,
    output t_out        o_out
);

    localparam int     AW    = (PATH_DEPTH > 1) ? $clog2(PATH_DEPTH) : 1;
    localparam int     CW    = $clog2(PATH_DEPTH + 1);
    localparam int     MOD_S = 10 + AW;
    localparam longint MOD_M = ((longint'(1) << MOD_S) + longint'(PATH_DEPTH) - 1)
                               / longint'(PATH_DEPTH);

    logic [10:0] r_path_len;
    logic [15:0] r_wheel, r_gain;
    t_in         r_in;

    logic signed [31:0] mem_x [PATH_DEPTH];
    logic signed [31:0] mem_y [PATH_DEPTH];
    logic signed [31:0] r_rdx, r_rdy;
    logic [AW-1:0]      w_rd_addr, w_slot;

    // slot remainder
    logic [9:0]  r_mod_v;
    logic        r_mod_done;
    logic [9:0]  w_mod_src, w_mod_q, w_mod_r;

    // cordic
    logic                    w_c_start, w_c_mode, w_c_done;
    logic signed [C_XYW-1:0] w_c_x, w_c_y, w_cx, w_cy;
    logic signed [C_ZW-1:0]  w_c_z, w_cz, w_zhead;
    logic signed [32:0]      w_ang_dx, w_ang_dy;

    // front axle
    logic signed [32:0] r_c30, r_s30;
    logic signed [49:0] r_mx, r_my;
    logic signed [31:0] r_fx, r_fy;
    logic signed [17:0] r_s14, r_c14;
    logic signed [27:0] w_shx, w_shy;
    logic signed [34:0] w_sumx, w_sumy;
    logic signed [33:0] w_rs14, w_rc14;

    // scan
    logic [CW-1:0]      r_cnt, w_n;
    logic               r_scan_act, r_first;
    logic               r_v1, r_v2, r_v3, r_l1, r_l2, r_l3, r_scan_done;
    logic [AW-1:0]      r_i1, r_i2, r_i3, r_nearest;
    logic signed [32:0] w_dx, w_dy, r_dx2, r_dy2, r_dx3, r_dy3, r_ndx, r_ndy;
    logic [31:0]        r_ax2, r_ay2;
    logic [63:0]        r_sqx, r_sqy;
    logic [64:0]        w_d, r_best;

    // error and steering
    logic signed [50:0] r_p1, r_p2;
    logic signed [51:0] w_diff;
    logic signed [37:0] w_errsh;
    logic signed [31:0] r_err;
    logic signed [48:0] r_gerr;
    logic signed [34:0] w_te, r_te;
    logic signed [35:0] w_sum;
    logic signed [20:0] w_delta;
    logic               w_tgt_last;
    logic               r_valid;
    t_out               r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_path_len <= 11'd1;
            r_wheel    <= 16'd256;
            r_gain     <= 16'd256;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_PATH_LENGTH) begin
                r_path_len <= i_cfg_data[10:0];
            end
            if (i_cfg_idx == CFG_WHEEL_BASE) begin
                r_wheel <= i_cfg_data;
            end
            if (i_cfg_idx == CFG_GAIN_K) begin
                r_gain <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_in <= i_in;
        end
    end

    // memories
    assign w_tgt_last = (32'(r_in.last_target) >= 32'(r_nearest));
    assign w_slot     = w_tgt_last ? AW'(r_mod_v) : r_nearest;
    assign w_rd_addr  = r_scan_act ? r_cnt[AW-1:0] : w_slot;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr) begin
            mem_x[AW'(r_mod_v)] <= r_in.point_x;
            mem_y[AW'(r_mod_v)] <= r_in.point_y;
        end
        r_rdx <= mem_x[w_rd_addr];
        r_rdy <= mem_y[w_rd_addr];
    end

    // remainder by PATH_DEPTH through reciprocal multiplication
    assign w_mod_src = i_cmd.ld_mod ? r_in.point_index : r_in.last_target;
    assign w_mod_q   = 10'((40'(w_mod_src) * 40'(MOD_M)) >> MOD_S);
    assign w_mod_r   = 10'(27'(w_mod_src) - 27'(w_mod_q) * 27'(PATH_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod_done <= 1'b0;
        end else if (i_cmd.ld_mod || i_cmd.tgt_mod) begin
            r_mod_v    <= w_mod_r;
            r_mod_done <= 1'b1;
        end
    end

    // cordic operand select
    assign w_zhead  = C_ZW'($signed({r_in.heading, 15'b0}));
    assign w_ang_dx = 33'(r_rdx) - 33'(r_in.pos_x);
    assign w_ang_dy = 33'(r_rdy) - 33'(r_in.pos_y);

    always_comb begin
        w_c_start = i_cmd.rot_start || i_cmd.ang_start || i_cmd.td_start;
        w_c_mode  = i_cmd.rot_start ? CM_ROT : CM_VEC;
        w_c_z     = w_zhead;
        if (i_cmd.ang_start) begin
            w_c_x = C_XYW'(w_ang_dx);
            w_c_y = C_XYW'(w_ang_dy);
        end else begin
            w_c_x = $signed({20'b0, r_in.speed, 16'b0});
            w_c_y = C_XYW'(r_gerr);
        end
    end

    spt_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_c_start),
        .i_mode  (w_c_mode),
        .i_x     (w_c_x),
        .i_y     (w_c_y),
        .i_z     (w_c_z),
        .o_done  (w_c_done),
        .o_x     (w_cx),
        .o_y     (w_cy),
        .o_z     (w_cz)
    );

    // front axle
    assign w_shx  = 28'((r_mx + 50'sd2097152) >>> 22);
    assign w_shy  = 28'((r_my + 50'sd2097152) >>> 22);
    assign w_sumx = 35'(r_in.pos_x) + 35'(w_shx);
    assign w_sumy = 35'(r_in.pos_y) + 35'(w_shy);
    assign w_rs14 = (34'(r_s30) + 34'sd32768) >>> 16;
    assign w_rc14 = (34'(r_c30) + 34'sd32768) >>> 16;

    always_ff @(posedge i_clk) begin
        if (i_cmd.front) begin
            r_c30 <= 33'(w_cx);
            r_s30 <= 33'(w_cy);
            r_mx  <= 50'($signed({1'b0, r_wheel}) * 33'(w_cx));
            r_my  <= 50'($signed({1'b0, r_wheel}) * 33'(w_cy));
        end
        if (i_cmd.front_sat) begin
            r_fx  <= sat32(64'(w_sumx));
            r_fy  <= sat32(64'(w_sumy));
            r_s14 <= 18'(w_rs14);
            r_c14 <= 18'(w_rc14);
        end
    end

    // nearest point scan, four stages
    always_comb begin
        if (r_path_len == 11'd0) begin
            w_n = CW'(1);
        end else if (32'(r_path_len) > 32'(PATH_DEPTH)) begin
            w_n = CW'(PATH_DEPTH);
        end else begin
            w_n = CW'(r_path_len);
        end
        w_dx = 33'(r_fx) - 33'(r_rdx);
        w_dy = 33'(r_fy) - 33'(r_rdy);
        w_d  = 65'(r_sqx) + 65'(r_sqy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_act  <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_scan_done <= 1'b0;
            r_first     <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_scan_done <= 1'b0;
            r_v1        <= r_scan_act;
            r_v2        <= r_v1;
            r_v3        <= r_v2;
            if (i_cmd.scan_start) begin
                r_scan_act <= 1'b1;
                r_cnt      <= '0;
                r_first    <= 1'b1;
            end else if (r_scan_act) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == w_n - CW'(1)) begin
                    r_scan_act <= 1'b0;
                end
            end
            if (r_v3) begin
                r_first <= 1'b0;
                if (r_l3) begin
                    r_scan_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_i1  <= r_cnt[AW-1:0];
        r_l1  <= (r_cnt == w_n - CW'(1));
        r_i2  <= r_i1;
        r_l2  <= r_l1;
        r_dx2 <= w_dx;
        r_dy2 <= w_dy;
        r_ax2 <= 32'((w_dx[32] ? -w_dx : w_dx) >>> 1);
        r_ay2 <= 32'((w_dy[32] ? -w_dy : w_dy) >>> 1);
        r_i3  <= r_i2;
        r_l3  <= r_l2;
        r_dx3 <= r_dx2;
        r_dy3 <= r_dy2;
        r_sqx <= r_ax2 * r_ax2;
        r_sqy <= r_ay2 * r_ay2;
        if (r_v3 && (r_first || (w_d < r_best))) begin
            r_best    <= w_d;
            r_nearest <= r_i3;
            r_ndx     <= r_dx3;
            r_ndy     <= r_dy3;
        end
    end

    // cross-track error and steering
    assign w_diff  = 52'(r_p1) - 52'(r_p2);
    assign w_errsh = 38'((w_diff + 52'sd8192) >>> 14);

    always_comb begin
        w_te = 35'(w_cz) - 35'(w_zhead);
        if (w_te > 35'(C_ANG_PI)) begin
            w_te = w_te - C_ANG_TWO_PI;
        end else if (w_te < -35'(C_ANG_PI)) begin
            w_te = w_te + C_ANG_TWO_PI;
        end
        w_sum   = 36'(r_te) + 36'(w_cz);
        w_delta = 21'((w_sum + 36'sd16384) >>> 15);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.err_mul) begin
            r_p1 <= 51'(r_ndx * r_s14);
            r_p2 <= 51'(r_ndy * r_c14);
        end
        if (i_cmd.err_fin) begin
            r_err <= sat32(64'(w_errsh));
        end
        if (i_cmd.ang_save) begin
            r_te   <= w_te;
            r_gerr <= 49'($signed({1'b0, r_gain}) * r_err);
        end
        if (i_cmd.out_fire) begin
            r_out.steering_angle    <= w_delta[16:0];
            r_out.target_index      <= w_tgt_last ? r_in.last_target : 10'(r_nearest);
            r_out.cross_track_error <= r_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.out_fire;
        end
    end

    assign o_stat.mod_done    = r_mod_done;
    assign o_stat.cordic_done = w_c_done;
    assign o_stat.scan_done   = r_scan_done;
    assign o_valid            = r_valid;
    assign o_out              = r_out;

endmodule

FILE: rtl/core/spt_ctrl.sv
// ----------------------------------------------------------------------------
// spt_ctrl
// Sequencer of the path tracker: steps the datapath through a load item
// or a tracking step and waits on its status.
// ----------------------------------------------------------------------------
module spt_ctrl
    import spt_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    input  logic  i_opcode,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  busy
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = (i_opcode == OP_TRACK) ? S_ROT : S_LD_MOD;
                end
            end
            S_LD_MOD:    n_state = S_LD_WAIT;
            S_LD_WAIT:   if (i_stat.mod_done) n_state = S_LD_WR;
            S_LD_WR:     n_state = S_IDLE;
            S_ROT:       n_state = S_ROT_WAIT;
            S_ROT_WAIT:  if (i_stat.cordic_done) n_state = S_FMUL;
            S_FMUL:      n_state = S_FSAT;
            S_FSAT:      n_state = S_SCAN;
            S_SCAN:      n_state = S_SCAN_WAIT;
            S_SCAN_WAIT: if (i_stat.scan_done) n_state = S_EMUL;
            S_EMUL:      n_state = S_EFIN;
            S_EFIN:      n_state = S_TMOD_WAIT;
            S_TMOD_WAIT: if (i_stat.mod_done) n_state = S_TRD;
            S_TRD:       n_state = S_ANG;
            S_ANG:       n_state = S_ANG_WAIT;
            S_ANG_WAIT:  if (i_stat.cordic_done) n_state = S_ANG_SAVE;
            S_ANG_SAVE:  n_state = S_TD;
            S_TD:        n_state = S_TD_WAIT;
            S_TD_WAIT:   if (i_stat.cordic_done) n_state = S_OUT;
            S_OUT:       n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE:     o_cmd.accept     = start;
            S_LD_MOD:   o_cmd.ld_mod     = 1'b1;
            S_LD_WR:    o_cmd.mem_wr     = 1'b1;
            S_ROT:      o_cmd.rot_start  = 1'b1;
            S_FMUL:     o_cmd.front      = 1'b1;
            S_FSAT:     o_cmd.front_sat  = 1'b1;
            S_SCAN:     o_cmd.scan_start = 1'b1;
            S_EMUL: begin
                o_cmd.err_mul = 1'b1;
                o_cmd.tgt_mod = 1'b1;
            end
            S_EFIN:     o_cmd.err_fin    = 1'b1;
            S_ANG:      o_cmd.ang_start  = 1'b1;
            S_ANG_SAVE: o_cmd.ang_save   = 1'b1;
            S_TD:       o_cmd.td_start   = 1'b1;
            S_OUT:      o_cmd.out_fire   = 1'b1;
            default:    o_cmd = '0;
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

FILE: rtl/core/stanley_path_tracker.sv
// ----------------------------------------------------------------------------
// stanley_path_tracker
// Stanley lateral steering controller over a stored path.
//
//   channel  | ports                              | handshake
//   ---------+------------------------------------+-----------------------
//   input    | i_in                               | start && !busy
//   result   | o_out                              | o_valid, one cycle
//   config   | i_cfg_idx, i_cfg_data              | i_cfg_we
//
// A load item or a tracking step keeps busy high until its sequence ends. In a
// tracking step the scan reads the points of the searched path, one point per
// memory cycle through a pipeline, and the three CORDIC passes share one
// iterative unit. The result strobe comes in the first cycle with busy low.
// Reset is synchronous; the path memories are not cleared. The result is shown
// for one cycle and the receiver cannot stall it.
// ----------------------------------------------------------------------------
module stanley_path_tracker
    import spt_pkg::*;
#(
    parameter int PATH_DEPTH   = C_PATH_DEPTH,
    parameter int CORDIC_STEPS = C_CORDIC_STEPS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  t_in         i_in,
    output logic        busy,
    output logic        o_valid,
    output t_out        o_out,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    t_cmd  w_cmd;
    t_stat w_stat;

    spt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_opcode (i_in.opcode),
        .i_stat   (w_stat),
        .o_cmd    (w_cmd),
        .busy     (busy)
    );

    spt_dp #(
        .PATH_DEPTH   (PATH_DEPTH),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_in       (i_in),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_valid    (o_valid),
        .o_out      (o_out)
    );

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for stanley_path_tracker. Load and track items are
// queued by an initial block and driven with random gaps or, in one phase,
// none; an in-bench fixed-point model of the tracker predicts each steering
// result, and a monitor compares every strobed result, field by field, in
// order. Register settings change between phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
    import spt_pkg::*;

    localparam int    WATCHDOG_LIMIT = 30000;
    localparam longint ANG_PI_L      = 843314857;
    localparam longint ANG_HPI_L     = 421657428;
    localparam longint ANG_2PI_L     = 1686629714;
    localparam longint GAIN30_L      = 652032874;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    t_in         i_in = '0;
    logic        busy;
    logic        o_valid;
    t_out        o_out;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = CFG_PATH_LENGTH;
    logic [15:0] i_cfg_data = '0;

    t_in    pending_items[$];
    t_out   steering_expected[$];
    int     errors = 0;
    int     quiet_cycles = 0;
    bit     no_gaps = 1'b0;

    int     path_x_mem[C_PATH_DEPTH];
    int     path_y_mem[C_PATH_DEPTH];
    longint len_reg = 1;
    longint wb_reg = 256;
    longint gain_reg = 256;

    bit     slot_loaded[C_PATH_DEPTH];
    int     loaded_slots[$];

    stanley_path_tracker dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_in       (i_in),
        .busy       (busy),
        .o_valid    (o_valid),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic longint rnd_shr(longint v, int n);
        return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint atan_step(int i);
        longint tab[24] = '{210828714, 124459457, 65760959, 33381290, 16755422,
            8385879, 4193963, 2097109, 1048571, 524287, 262144, 131072, 65536,
            32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32};
        return tab[i];
    endfunction

    task automatic sin_cos(input longint za, output longint s, output longint c);
        longint x, y, z, xs, ys;
        bit     flip;
        x = GAIN30_L;
        y = 0;
        z = za;
        flip = 1'b0;
        if (z > ANG_HPI_L) begin
            z -= ANG_PI_L;
            flip = 1'b1;
        end else if (z < -ANG_HPI_L) begin
            z += ANG_PI_L;
            flip = 1'b1;
        end
        for (int i = 0; i < C_CORDIC_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x -= ys; y += xs; z -= atan_step(i);
            end else begin
                x += ys; y -= xs; z += atan_step(i);
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        s = y;
        c = x;
    endtask

    function automatic longint bearing(longint ya, longint xa);
        longint x, y, z, t, xs, ys;
        x = xa;
        y = ya;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; z = ANG_HPI_L;
            end else begin
                t = x; x = -y; y = t; z = -ANG_HPI_L;
            end
        end
        for (int i = 0; i < C_CORDIC_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y < 0) begin
                x -= ys; y += xs; z -= atan_step(i);
            end else begin
                x += ys; y -= xs; z += atan_step(i);
            end
        end
        return z;
    endfunction

    task automatic track_step(input t_in it);
        longint px, py, z, s30, c30, fx, fy, s14, c14, err, ang, te, td, delta;
        longint ndx, ndy, dx, dy, ax, ay, d, best, n, nearest, tgt;
        t_out   r;
        if (it.opcode == OP_LOAD) begin
            path_x_mem[it.point_index] = it.point_x;
            path_y_mem[it.point_index] = it.point_y;
        end else begin
            px = longint'($signed(it.pos_x));
            py = longint'($signed(it.pos_y));
            z = longint'($signed(it.heading)) * 32768;
            sin_cos(z, s30, c30);
            fx = clip32(px + rnd_shr(wb_reg * c30, 22));
            fy = clip32(py + rnd_shr(wb_reg * s30, 22));
            n = len_reg;
            if (n == 0) n = 1;
            if (n > C_PATH_DEPTH) n = C_PATH_DEPTH;
            best = 0; nearest = 0; ndx = 0; ndy = 0;
            for (int i = 0; i < n; i++) begin
                dx = fx - longint'(path_x_mem[i]);
                dy = fy - longint'(path_y_mem[i]);
                ax = (dx < 0 ? -dx : dx) >> 1;
                ay = (dy < 0 ? -dy : dy) >> 1;
                d = ax * ax + ay * ay;
                if (i == 0 || d < best) begin
                    best = d; nearest = i; ndx = dx; ndy = dy;
                end
            end
            s14 = rnd_shr(s30, 16);
            c14 = rnd_shr(c30, 16);
            err = clip32(rnd_shr(ndx * s14 - ndy * c14, 14));
            tgt = (longint'(it.last_target) >= nearest) ? longint'(it.last_target) : nearest;
            ang = bearing(longint'(path_y_mem[tgt]) - py, longint'(path_x_mem[tgt]) - px);
            te = ang - z;
            while (te > ANG_PI_L) te -= ANG_2PI_L;
            while (te < -ANG_PI_L) te += ANG_2PI_L;
            td = bearing(gain_reg * err, longint'(it.speed) * 65536);
            delta = rnd_shr(te + td, 15);
            r.steering_angle = delta[16:0];
            r.target_index = tgt[9:0];
            r.cross_track_error = err[31:0];
            steering_expected.push_back(r);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) track_step(i_in);
            if (!start || !busy) begin
                if (pending_items.size() > 0 && (no_gaps || $urandom_range(99) >= 19)) begin
                    start <= 1'b1;
                    i_in <= pending_items.pop_front();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_out e;
        if (i_rst_n && o_valid) begin
            if (steering_expected.size() == 0) begin
                $error("unexpected result: steering_angle %0d", $signed(o_out.steering_angle));
                errors++;
            end else begin
                e = steering_expected.pop_front();
                if (o_out.steering_angle !== e.steering_angle) begin
                    $error("steering_angle expected %0d actual %0d",
                           $signed(e.steering_angle), $signed(o_out.steering_angle));
                    errors++;
                end
                if (o_out.target_index !== e.target_index) begin
                    $error("target_index expected %0d actual %0d",
                           e.target_index, o_out.target_index);
                    errors++;
                end
                if (o_out.cross_track_error !== e.cross_track_error) begin
                    $error("cross_track_error expected %0d actual %0d",
                           $signed(e.cross_track_error), $signed(o_out.cross_track_error));
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic void push_load(int idx, int x, int y);
        t_in it;
        it = t_in'($bits(t_in)'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                 $urandom}));
        it.opcode = OP_LOAD;
        it.point_index = idx[9:0];
        it.point_x = x;
        it.point_y = y;
        if (!slot_loaded[idx]) begin
            slot_loaded[idx] = 1'b1;
            loaded_slots.push_back(idx);
        end
        pending_items.push_back(it);
    endfunction

    function automatic void push_track(int px, int py, int h, int sp, int lt);
        t_in it;
        it = t_in'($bits(t_in)'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                 $urandom}));
        it.opcode = OP_TRACK;
        it.pos_x = px;
        it.pos_y = py;
        it.heading = h[15:0];
        it.speed = sp[15:0];
        it.last_target = lt[9:0];
        pending_items.push_back(it);
    endfunction

    function automatic int any_loaded();
        return loaded_slots[$urandom_range(loaded_slots.size() - 1)];
    endfunction

    function automatic void fill_prefix(longint n);
        for (int i = 0; i < n && i < C_PATH_DEPTH; i++) begin
            if (!slot_loaded[i]) push_load(i, $urandom, $urandom);
        end
    endfunction

    function automatic int path_x_mem_shadow(int idx);
        foreach (pending_items[j]) begin
            if (pending_items[j].opcode == OP_LOAD && pending_items[j].point_index == idx)
                return pending_items[j].point_x;
        end
        return path_x_mem[idx];
    endfunction

    function automatic int path_y_mem_shadow(int idx);
        foreach (pending_items[j]) begin
            if (pending_items[j].opcode == OP_LOAD && pending_items[j].point_index == idx)
                return pending_items[j].point_y;
        end
        return path_y_mem[idx];
    endfunction

    function automatic void push_random(int count, int slot_span);
        int base, p, h;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(99) < 25) begin
                p = $urandom_range(slot_span - 1);
                if ($urandom_range(3) == 0) p = $urandom_range(C_PATH_DEPTH - 1);
                if ($urandom_range(1)) push_load(p, $urandom, $urandom);
                else push_load(p, $urandom_range(65535 * 64) - 65535 * 32,
                               $urandom_range(65535 * 64) - 65535 * 32);
            end else begin
                base = any_loaded();
                h = ($urandom_range(9) == 0) ? int'($urandom_range(65535)) - 32768
                                             : int'($urandom_range(51472)) - 25736;
                if ($urandom_range(2) == 0) begin
                    push_track($urandom, $urandom, h, $urandom, any_loaded());
                end else begin
                    push_track(path_x_mem_shadow(base) + int'($urandom_range(1 << 20)) - (1 << 19),
                               path_y_mem_shadow(base) + int'($urandom_range(1 << 20)) - (1 << 19),
                               h, $urandom_range(65535), any_loaded());
                end
            end
        end
    endfunction

    task automatic settle();
        do @(posedge i_clk);
        while (pending_items.size() != 0 || start || busy || steering_expected.size() != 0);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_regs(int pl, int wb, int gk);
        settle();
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_PATH_LENGTH;
        i_cfg_data <= pl[15:0];
        len_reg = pl & 32'h7FF;
        @(posedge i_clk);
        i_cfg_idx <= CFG_WHEEL_BASE;
        i_cfg_data <= wb[15:0];
        wb_reg = wb & 32'hFFFF;
        @(posedge i_clk);
        i_cfg_idx <= CFG_GAIN_K;
        i_cfg_data <= gk[15:0];
        gain_reg = gk & 32'hFFFF;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_load(0, 32'sh7fffffff, 32'sh80000000);
        push_load(1, 32'sh80000000, 32'sh7fffffff);
        push_load(2, 0, 0);
        push_load(1023, 32'sh00010000, -32'sh00010000);
        push_load(5, 32'sh7fffffff, 32'sh7fffffff);
        push_track(0, 0, 0, 0, 0);
        push_track(32'sh7fffffff, 32'sh7fffffff, 25736, 65535, 1023);
        push_track(32'sh80000000, 32'sh80000000, -25736, 0, 1);
        push_track(32'sh7fffffff, 0, 32767, 256, 2);
        push_track(0, 32'sh80000000, -32768, 1, 5);
        push_track(12345, -54321, 12868, 4096, 0);
        push_track(-1, 1, -12868, 65535, 1023);

        set_regs(0, 0, 0);
        push_track(32'sh7fffffff, 32'sh80000000, 0, 0, 0);
        push_track(0, 0, 25736, 0, 2);
        push_track(32'sh00010000, -32'sh00010000, 0, 0, 1023);
        fill_prefix(1);
        push_random(60, 16);

        set_regs(8, 65535, 65535);
        fill_prefix(8);
        push_track(32'sh7fffffff, 32'sh7fffffff, 0, 0, 0);
        push_track(32'sh80000000, 32'sh80000000, -25736, 65535, 5);
        push_random(100, 16);

        set_regs(16, $urandom_range(65535), $urandom_range(65535));
        fill_prefix(16);
        settle();
        no_gaps = 1'b1;
        push_random(150, 32);
        settle();
        no_gaps = 1'b0;
        push_random(100, 32);

        set_regs(1, 256, 256);
        push_random(60, 64);

        set_regs(40, $urandom_range(4096), $urandom_range(65535));
        fill_prefix(40);
        push_random(45, 64);

        settle();
        repeat (50) @(posedge i_clk);
        if (errors == 0 && steering_expected.size() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
